// ----- hw/rtl/threshold_block_selector_top_defines.svh -----
// assertion macros used by the selector rtl
`ifndef THRESHOLD_BLOCK_SELECTOR_TOP_DEFINES_SVH
`define THRESHOLD_BLOCK_SELECTOR_TOP_DEFINES_SVH

// condition holds in the same cycle
`define TBS_ASSERT_NOW(lbl, cond_a, cond_c, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_c)) \
      else $error(msg);

// condition holds in the next cycle
`define TBS_ASSERT_NEXT(lbl, cond_a, cond_c, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_c)) \
      else $error(msg);

`endif

// ----- hw/rtl/tbs_pkg.sv -----
`default_nettype none
package tbs_pkg;

   // defaults for top level parameters
   localparam int MAX_KV_BLOCKS_DEF = 64;
   localparam int MAX_Q_BLOCKS_DEF  = 256;
   localparam int FRAC_BITS_DEF     = 16;

   // field and datapath widths
   localparam int Q_W      = 8;
   localparam int KV_W     = 6;
   localparam int VAL_W    = 32;
   localparam int MASK_W   = 64;
   localparam int TOTAL_W  = 40;
   localparam int THR_W    = 17;
   localparam int THR_FRAC = 16;
   localparam int NKV_W    = 7;
   localparam int NQ_W     = 13;
   localparam int POS_W    = 14;
   localparam int ACC_W    = 39;
   localparam int NEED_W   = TOTAL_W + THR_W;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // register port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      REG_THRESHOLD   = 3'd0,
      REG_KEEP_SINK   = 3'd1,
      REG_KEEP_RECENT = 3'd2,
      REG_CAUSAL      = 3'd3,
      REG_N_Q_BLOCKS  = 3'd4,
      REG_N_KV_BLOCKS = 3'd5
   } csr_reg_type;

   localparam logic [THR_W-1:0] THRESHOLD_RST = 17'd58982;
   localparam logic [8:0]       N_Q_RST       = 9'd1;
   localparam logic [NKV_W-1:0] N_KV_RST      = 7'd1;

   // effective configuration seen by the datapath
   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic             sink_en;
      logic             recent_en;
      logic             causal;
      logic [NQ_W-1:0]  nq;
      logic [NKV_W-1:0] nkv;
   } tbs_cfg_type;

   // one column of a finished row, front to back
   typedef struct packed {
      logic [VAL_W-1:0]   value;
      logic [KV_W-1:0]    col;
      logic               forced;
      logic               last;
      logic [Q_W-1:0]     row;
      logic [TOTAL_W-1:0] total;
   } tbs_entry_type;

   // diagonal column of a row, may be negative
   function automatic logic signed [POS_W-1:0] tbs_pos(
      input logic [NKV_W-1:0] nkv,
      input logic [NQ_W-1:0]  nq,
      input logic [Q_W-1:0]   row
   );
      return $signed(POS_W'(nkv)) - $signed(POS_W'(nq)) + $signed(POS_W'(row));
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tbs_if.sv -----
`default_nettype none
// request channel
interface tbs_req_if import tbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [Q_W-1:0]   q_block;
   logic [KV_W-1:0]  kv_block;
   logic [VAL_W-1:0] attn_value;

   modport source (output valid, q_block, kv_block, attn_value, input ready);
   modport sink (input valid, q_block, kv_block, attn_value, output ready);
endinterface

// result channel
interface tbs_rsp_if import tbs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [Q_W-1:0]    row_index;
   logic [MASK_W-1:0] keep_mask;

   modport source (output valid, row_index, keep_mask, input ready);
   modport sink (input valid, row_index, keep_mask, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tbs_queue.sv -----
`default_nettype none
module tbs_queue import tbs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  tbs_entry_type      push_data,
   input  wire logic          pop,
   output logic               pop_valid,
   output tbs_entry_type      pop_data,
   output logic [QCNT_W-1:0]  count
);

   tbs_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/tbs_front.sv -----
`default_nettype none
module tbs_front import tbs_pkg::*; #(
   parameter int MAX_KV_BLOCKS = MAX_KV_BLOCKS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   tbs_req_if.sink           req,
   input  tbs_cfg_type       cfg,
   output logic              q_push,
   output tbs_entry_type     q_data,
   input  wire logic [QCNT_W-1:0] q_count
);

   localparam int COL_W = $clog2(MAX_KV_BLOCKS);

   typedef enum logic [1:0] {
      F_ACCEPT = 2'b01,
      F_SWEEP  = 2'b10
   } front_state_type;

   front_state_type     state_ff, state_in;
   logic [VAL_W-1:0]    mem [MAX_KV_BLOCKS];
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [TOTAL_W-1:0]  job_total_ff;
   logic [Q_W-1:0]      job_row_ff;
   logic [NKV_W-1:0]    issue_ff, issue_in;
   logic                pend_ff;
   logic [NKV_W-1:0]    pend_col_ff;
   logic [VAL_W-1:0]    rd_data_ff;
   logic                accept, col_ok, wr, row_end, issue, last;
   logic [TOTAL_W:0]    sum_wide;
   logic [TOTAL_W-1:0]  sum_sat;
   logic signed [POS_W-1:0] pos;
   logic                f_sink, f_recent;

   // request decode
   assign req.ready = (state_ff == F_ACCEPT);
   assign accept    = req.valid && req.ready;
   assign col_ok    = (NKV_W'(req.kv_block) < cfg.nkv);
   assign wr        = accept && col_ok;
   assign row_end   = wr && (NKV_W'(req.kv_block) == cfg.nkv - NKV_W'(1));

   // saturating row total
   assign sum_wide = {1'b0, total_ff} + (TOTAL_W+1)'(req.attn_value);
   assign sum_sat  = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];

   always_comb begin
      total_in = total_ff;
      if (row_end) begin
         total_in = '0;
      end else if (wr) begin
         total_in = sum_sat;
      end
   end

   // sweep reads the row out, one column a cycle, while the queue has room
   assign issue = (state_ff == F_SWEEP) && (issue_ff < cfg.nkv)
                  && ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(pend_ff) < (QCNT_W+1)'(QUEUE_DEPTH));
   assign last  = (pend_col_ff == cfg.nkv - NKV_W'(1));

   always_comb begin
      issue_in = issue_ff;
      if (row_end) begin
         issue_in = '0;
      end else if (issue) begin
         issue_in = issue_ff + NKV_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_ACCEPT: if (row_end) state_in = F_SWEEP;
         F_SWEEP:  if (pend_ff && last) state_in = F_ACCEPT;
         default:  state_in = F_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_ACCEPT;
         total_ff <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         issue_ff <= issue_in;
         pend_ff  <= issue;
      end
   end

   // column store and job header
   always_ff @(posedge clock) begin
      if (wr) begin
         mem[req.kv_block[COL_W-1:0]] <= req.attn_value;
      end
      if (issue) begin
         rd_data_ff  <= mem[issue_ff[COL_W-1:0]];
         pend_col_ff <= issue_ff;
      end
      if (row_end) begin
         job_total_ff <= sum_sat;
         job_row_ff   <= req.q_block;
      end
   end

   // classify sink and recent columns
   assign pos      = tbs_pos(cfg.nkv, cfg.nq, job_row_ff);
   assign f_sink   = cfg.sink_en && (pend_col_ff == '0);
   assign f_recent = cfg.recent_en && !pos[POS_W-1]
                     && (pos[POS_W-2:0] == (POS_W-1)'(pend_col_ff));

   assign q_push        = pend_ff;
   assign q_data.value  = rd_data_ff;
   assign q_data.col    = pend_col_ff[KV_W-1:0];
   assign q_data.forced = f_sink || f_recent;
   assign q_data.last   = last;
   assign q_data.row    = job_row_ff;
   assign q_data.total  = job_total_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/tbs_back.sv -----
`default_nettype none
`include "threshold_block_selector_top_defines.svh"
module tbs_back import tbs_pkg::*; #(
   parameter int MAX_KV_BLOCKS = MAX_KV_BLOCKS_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  tbs_cfg_type   cfg,
   input  wire logic     q_valid,
   input  tbs_entry_type q_data,
   output logic          q_pop,
   tbs_rsp_if.source     rsp
);

   localparam int COL_W = $clog2(MAX_KV_BLOCKS);

   typedef enum logic [3:0] {
      B_INSERT = 4'b0001,
      B_DRAIN  = 4'b0010,
      B_TAIL   = 4'b0100,
      B_FINISH = 4'b1000
   } back_state_type;

   back_state_type     state_ff, state_in;

   // sorted cells, key is forced flag over mass
   logic [VAL_W:0]     key_ff [MAX_KV_BLOCKS];
   logic [VAL_W:0]     key_in [MAX_KV_BLOCKS];
   logic [COL_W-1:0]   ccol_ff [MAX_KV_BLOCKS];
   logic [COL_W-1:0]   ccol_in [MAX_KV_BLOCKS];
   logic [MAX_KV_BLOCKS-1:0] cvld_ff, cvld_in, beats;

   logic [ACC_W-1:0]   fsum_ff, s_ff, acc_now, sub;
   logic [1:0]         nf_ff;
   logic [VAL_W-1:0]   p1_ff, p2_ff;
   logic [NKV_W-1:0]   slot_ff;
   logic [Q_W-1:0]     row_ff;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [TOTAL_W-1:0] base;
   logic [MAX_KV_BLOCKS-1:0] mask_ff, fin_mask;
   logic               cmp_vld_ff;
   logic [ACC_W-1:0]   cmp_acc_ff;
   logic [COL_W-1:0]   cmp_col_ff;
   logic               rsp_vld_ff;
   logic [Q_W-1:0]     rsp_row_ff;
   logic [MAX_KV_BLOCKS-1:0] rsp_mask_ff;
   logic               ins, drain, out_free, done;
   logic [VAL_W:0]     new_key;
   logic [VAL_W-1:0]   head_val;
   logic               head_forced;
   logic signed [POS_W-1:0] pos;

   assign ins      = (state_ff == B_INSERT) && q_valid;
   assign drain    = (state_ff == B_DRAIN);
   assign q_pop    = ins;
   assign out_free = !rsp_vld_ff || rsp.ready;
   assign done     = (state_ff == B_FINISH) && out_free;
   assign new_key  = {q_data.forced, q_data.value};

   // insertion: a new request goes in front of every cell it outranks
   always_comb begin
      for (int k = 0; k < MAX_KV_BLOCKS; k++) begin
         beats[k] = !cvld_ff[k] || (new_key > key_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_KV_BLOCKS; k++) begin
         key_in[k]  = key_ff[k];
         ccol_in[k] = ccol_ff[k];
         cvld_in[k] = cvld_ff[k];
      end
      if (ins) begin
         for (int k = 0; k < MAX_KV_BLOCKS; k++) begin
            if (beats[k]) begin
               key_in[k]  = new_key;
               ccol_in[k] = q_data.col[COL_W-1:0];
               cvld_in[k] = 1'b1;
            end
         end
         for (int k = 1; k < MAX_KV_BLOCKS; k++) begin
            if (beats[k-1]) begin
               key_in[k]  = key_ff[k-1];
               ccol_in[k] = ccol_ff[k-1];
               cvld_in[k] = cvld_ff[k-1];
            end
         end
      end else if (drain) begin
         for (int k = 0; k < MAX_KV_BLOCKS - 1; k++) begin
            key_in[k]  = key_ff[k+1];
            ccol_in[k] = ccol_ff[k+1];
            cvld_in[k] = cvld_ff[k+1];
         end
         cvld_in[MAX_KV_BLOCKS-1] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_KV_BLOCKS; k++) begin
         key_ff[k]  <= key_in[k];
         ccol_ff[k] <= ccol_in[k];
      end
   end

   // needed mass for the row
   assign base    = (q_data.total == '0) ? TOTAL_W'(64'd1 << FRAC_BITS) : q_data.total;
   assign need_in = base * cfg.threshold;

   // covered mass: forced sum, then non-forced masses lagging by the free slots
   assign head_val    = key_ff[0][VAL_W-1:0];
   assign head_forced = key_ff[0][VAL_W];
   always_comb begin
      case (nf_ff)
         2'd0:    sub = ACC_W'(p1_ff) + ACC_W'(p2_ff);
         2'd1:    sub = ACC_W'(p1_ff);
         default: sub = '0;
      endcase
      acc_now = (slot_ff < NKV_W'(2)) ? '0 : fsum_ff + s_ff - sub;
   end

   // state sequencing
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_INSERT: if (ins && q_data.last) state_in = B_DRAIN;
         B_DRAIN:  if (slot_ff == cfg.nkv - NKV_W'(1)) state_in = B_TAIL;
         B_TAIL:   state_in = B_FINISH;
         B_FINISH: if (out_free) state_in = B_INSERT;
         default:  state_in = B_INSERT;
      endcase
   end

   // cut rules on the ranked mask
   assign pos = tbs_pos(cfg.nkv, cfg.nq, row_ff);
   always_comb begin
      logic [MAX_KV_BLOCKS-1:0] m, full, gt;
      logic row_lt_nkv, row_lt_nq;
      row_lt_nkv = (row_ff < Q_W'(cfg.nkv));
      row_lt_nq  = (NQ_W'(row_ff) < cfg.nq);
      for (int k = 0; k < MAX_KV_BLOCKS; k++) begin
         full[k] = (NKV_W'(k) < cfg.nkv);
         gt[k]   = ($signed(POS_W'(k)) > pos);
      end
      m = mask_ff;
      for (int k = 1; k < MAX_KV_BLOCKS; k++) begin
         if (cfg.causal && row_lt_nkv && gt[k]) m[k] = 1'b0;
      end
      if (cfg.nq <= NQ_W'(cfg.nkv)) begin
         for (int k = 0; k < MAX_KV_BLOCKS; k++) begin
            if (row_lt_nq && gt[k]) m[k] = 1'b0;
         end
         if (cfg.sink_en && (row_ff == '0)) m = full;
         for (int k = 0; k < MAX_KV_BLOCKS; k++) begin
            if (cfg.recent_en && row_lt_nq && (pos == $signed(POS_W'(k)))) m[k] = 1'b1;
         end
      end
      fin_mask = m & full;
   end

   // control and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_INSERT;
         cvld_ff    <= '0;
         fsum_ff    <= '0;
         nf_ff      <= '0;
         s_ff       <= '0;
         p1_ff      <= '0;
         p2_ff      <= '0;
         slot_ff    <= '0;
         mask_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cvld_ff    <= cvld_in;
         cmp_vld_ff <= drain;
         if (ins && q_data.forced) begin
            fsum_ff <= fsum_ff + ACC_W'(q_data.value);
            nf_ff   <= nf_ff + 2'd1;
         end
         if (drain) begin
            slot_ff <= slot_ff + NKV_W'(1);
            if (!head_forced) begin
               s_ff  <= s_ff + ACC_W'(head_val);
               p1_ff <= head_val;
               p2_ff <= p1_ff;
            end
         end
         if (cmp_vld_ff) begin
            if (NEED_W'({cmp_acc_ff, {THR_FRAC{1'b0}}}) < need_ff) begin
               mask_ff[cmp_col_ff] <= 1'b1;
            end else begin
               mask_ff[0] <= 1'b1;
            end
         end
         if (done) begin
            fsum_ff    <= '0;
            nf_ff      <= '0;
            s_ff       <= '0;
            p1_ff      <= '0;
            p2_ff      <= '0;
            slot_ff    <= '0;
            mask_ff    <= '0;
            rsp_vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ins && q_data.last) begin
         row_ff  <= q_data.row;
         need_ff <= need_in;
      end
      if (drain) begin
         cmp_acc_ff <= acc_now;
         cmp_col_ff <= ccol_ff[0];
      end
      if (done) begin
         rsp_row_ff  <= row_ff;
         rsp_mask_ff <= fin_mask;
      end
   end

   assign rsp.valid     = rsp_vld_ff;
   assign rsp.row_index = rsp_row_ff;
   assign rsp.keep_mask = MASK_W'(rsp_mask_ff);

   `TBS_ASSERT_NOW(a_drain_no_pop, state_ff == B_DRAIN, !q_pop, "queue popped while draining")
   `TBS_ASSERT_NOW(a_drain_head_valid, state_ff == B_DRAIN, cvld_ff[0], "drain ran past the cells")
   `TBS_ASSERT_NEXT(a_finish_loads, done, rsp_vld_ff, "finished row not loaded")

endmodule
`default_nettype wire

// ----- hw/rtl/threshold_block_selector_top.sv -----
// Threshold block selector: builds a keep mask per query block row from
// block attention masses.
// Channels: req_chan carries one mass per request (q_block, kv_block,
// attn_value), row-major, columns in order; rsp_chan returns row_index and
// keep_mask once the last column (n_kv_blocks-1) of a row has arrived.
// Registers are to be written over the csr_ APB port only while the block
// is idle; the block itself does not enforce this.
// Flow: the front takes the N requests of a row, then stalls while it reads
// the row out into the sorter; the back walks the ranked row while the next
// row comes in.
// The sorter takes one column a cycle while the queue holds one and the back
// is inserting, and the walk one rank slot a cycle.
// Reset clears the row total, the queue and the sorter and loads register
// defaults. A stalled result holds in the output register; the back keeps
// sorting the next row and waits only when a second result is ready.
`default_nettype none
module threshold_block_selector_top import tbs_pkg::*; #(
   parameter int MAX_KV_BLOCKS = MAX_KV_BLOCKS_DEF,
   parameter int MAX_Q_BLOCKS  = MAX_Q_BLOCKS_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tbs_req_if.sink                req_chan,
   tbs_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [THR_W-1:0] thr_ff;
   logic             sink_ff, recent_ff, causal_ff;
   logic [8:0]       nq_reg_ff;
   logic [NKV_W-1:0] nkv_reg_ff;
   logic             csr_wr;
   csr_reg_type      csr_idx;
   tbs_cfg_type      cfg;
   tbs_entry_type    push_data, pop_data;
   logic             push, pop, pop_valid;
   logic [QCNT_W-1:0] q_count;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THRESHOLD_RST;
         sink_ff    <= 1'b1;
         recent_ff  <= 1'b1;
         causal_ff  <= 1'b1;
         nq_reg_ff  <= N_Q_RST;
         nkv_reg_ff <= N_KV_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_THRESHOLD:   thr_ff     <= csr_pwdata[THR_W-1:0];
            REG_KEEP_SINK:   sink_ff    <= csr_pwdata[0];
            REG_KEEP_RECENT: recent_ff  <= csr_pwdata[0];
            REG_CAUSAL:      causal_ff  <= csr_pwdata[0];
            REG_N_Q_BLOCKS:  nq_reg_ff  <= csr_pwdata[8:0];
            REG_N_KV_BLOCKS: nkv_reg_ff <= csr_pwdata[NKV_W-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_THRESHOLD:   csr_prdata = CSR_DW'(thr_ff);
         REG_KEEP_SINK:   csr_prdata = CSR_DW'(sink_ff);
         REG_KEEP_RECENT: csr_prdata = CSR_DW'(recent_ff);
         REG_CAUSAL:      csr_prdata = CSR_DW'(causal_ff);
         REG_N_Q_BLOCKS:  csr_prdata = CSR_DW'(nq_reg_ff);
         REG_N_KV_BLOCKS: csr_prdata = CSR_DW'(nkv_reg_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // clamp sizes into range
   always_comb begin
      cfg.threshold = thr_ff;
      cfg.sink_en   = sink_ff;
      cfg.recent_en = recent_ff;
      cfg.causal    = causal_ff;
      if (nkv_reg_ff == '0) begin
         cfg.nkv = NKV_W'(1);
      end else if (nkv_reg_ff > NKV_W'(MAX_KV_BLOCKS)) begin
         cfg.nkv = NKV_W'(MAX_KV_BLOCKS);
      end else begin
         cfg.nkv = nkv_reg_ff;
      end
      if (nq_reg_ff == '0) begin
         cfg.nq = NQ_W'(1);
      end else if (NQ_W'(nq_reg_ff) > NQ_W'(MAX_Q_BLOCKS)) begin
         cfg.nq = NQ_W'(MAX_Q_BLOCKS);
      end else begin
         cfg.nq = NQ_W'(nq_reg_ff);
      end
   end

   tbs_front #(
      .MAX_KV_BLOCKS (MAX_KV_BLOCKS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .cfg     (cfg),
      .q_push  (push),
      .q_data  (push_data),
      .q_count (q_count)
   );

   tbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .count     (q_count)
   );

   tbs_back #(
      .MAX_KV_BLOCKS (MAX_KV_BLOCKS),
      .FRAC_BITS     (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (pop_valid),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_chan)
   );

endmodule
`default_nettype wire
